FILE: hdl/pda_pkg.sv
package pda_pkg;

    localparam int DEF_NUM_STATES    = 16;
    localparam int DEF_TABLE_ENTRIES = 64;
    localparam int DEF_STACK_DEPTH   = 256;
    localparam int DEF_EPSILON_LIMIT = 16;

    localparam int SYM_W    = 8;
    localparam int STATE_W  = 4;
    localparam int DEPTH_W  = 9;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int MASK_W   = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [SYM_W-1:0] BOTTOM_RESET = 8'd126;
    localparam logic [SYM_W-1:0] EPSILON_SYM  = 8'd0;

    localparam logic [CFG_IDX_W-1:0] REG_INITIAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEPT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM  = 2'd2;

    typedef enum logic [1:0] {
        ACT_ALPHA = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_FEED  = 2'd2,
        ACT_END   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        SOP_NONE    = 2'd0,
        SOP_PUSH    = 2'd1,
        SOP_POP     = 2'd2,
        SOP_REPLACE = 2'd3
    } stack_op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_MOVE    = 3'd1,
        ST_NOT_ALPHA  = 3'd2,
        ST_BOTTOM_POP = 3'd3,
        ST_OVERFLOW   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MATCH,
        BK_SELECT,
        BK_REFILL,
        BK_RESULT
    } back_state_t;

    typedef struct packed {
        action_t              action;
        logic                 in_alpha;
        logic [SLOT_W-1:0]    entry_index;
        logic                 entry_valid;
        logic [STATE_W-1:0]   from_state;
        logic [SYM_W-1:0]     symbol;
        logic [SYM_W-1:0]     stack_key;
        logic [STATE_W-1:0]   to_state;
        stack_op_t            stack_op;
        logic [SYM_W-1:0]     push_char;
    } cmd_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } queue_ctl_t;

    localparam int QUEUE_DEPTH = 2;

endpackage

FILE: hdl/pda_front.sv
module pda_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [1:0]                    action,
    input  logic [pda_pkg::SYM_W-1:0]     symbol,
    input  logic                          member,
    input  logic [pda_pkg::SLOT_W-1:0]    entry_index,
    input  logic                          entry_valid,
    input  logic [pda_pkg::STATE_W-1:0]   from_state,
    input  logic [pda_pkg::SYM_W-1:0]     stack_key,
    input  logic [pda_pkg::STATE_W-1:0]   to_state,
    input  logic [1:0]                    stack_op,
    input  logic [pda_pkg::SYM_W-1:0]     push_char,
    input  logic                          q_full,
    output logic                          q_push,
    output pda_pkg::cmd_t                 q_data
);

    localparam int ALPHA_N = 1 << pda_pkg::SYM_W;

    logic [ALPHA_N-1:0] alpha_reg;
    logic [ALPHA_N-1:0] alpha_next;

    assign item_ready = !q_full;
    assign q_push     = item_valid && !q_full;

    always_comb
    begin
        alpha_next = alpha_reg;
        if (q_push && pda_pkg::action_t'(action) == pda_pkg::ACT_ALPHA)
        begin
            alpha_next[symbol] = member;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= '0;
        end
        else
        begin
            alpha_reg <= alpha_next;
        end
    end

    always_comb
    begin
        q_data.action      = pda_pkg::action_t'(action);
        q_data.in_alpha    = alpha_reg[symbol];
        q_data.entry_index = entry_index;
        q_data.entry_valid = entry_valid;
        q_data.from_state  = from_state;
        q_data.symbol      = symbol;
        q_data.stack_key   = stack_key;
        q_data.to_state    = to_state;
        q_data.stack_op    = pda_pkg::stack_op_t'(stack_op);
        q_data.push_char   = push_char;
    end

endmodule

FILE: hdl/pda_queue.sv
module pda_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pda_pkg::cmd_t       wr_data,
    input  logic                pop,
    output pda_pkg::cmd_t       rd_data,
    output pda_pkg::queue_ctl_t ctl
);

    localparam int PW = $clog2(pda_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(pda_pkg::QUEUE_DEPTH + 1);

    pda_pkg::cmd_t slot_reg [pda_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign ctl.full  = (count_reg == CW'(pda_pkg::QUEUE_DEPTH));
    assign ctl.empty = (count_reg == '0);
    assign do_push   = push && !ctl.full;
    assign do_pop    = pop && !ctl.empty;
    assign ctl.push  = do_push;
    assign ctl.pop   = do_pop;
    assign rd_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: hdl/pda_back.sv
module pda_back #(
    parameter int NUM_STATES    = pda_pkg::DEF_NUM_STATES,
    parameter int TABLE_ENTRIES = pda_pkg::DEF_TABLE_ENTRIES,
    parameter int STACK_DEPTH   = pda_pkg::DEF_STACK_DEPTH,
    parameter int EPSILON_LIMIT = pda_pkg::DEF_EPSILON_LIMIT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  pda_pkg::cmd_t                 q_data,
    input  logic [pda_pkg::STATE_W-1:0]   initial_state_cfg,
    input  logic [pda_pkg::MASK_W-1:0]    accept_mask_cfg,
    input  logic [pda_pkg::SYM_W-1:0]     bottom_cfg,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [pda_pkg::STATUS_W-1:0]  status,
    output logic [pda_pkg::STATE_W-1:0]   state_now,
    output logic [pda_pkg::DEPTH_W-1:0]   depth_now,
    output logic                          word_done,
    output logic                          accepted
);

    localparam int TW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int EW  = $clog2(EPSILON_LIMIT + 1);
    localparam int SW  = pda_pkg::SYM_W;
    localparam int QW  = pda_pkg::STATE_W;

    pda_pkg::back_state_t fsm_reg, fsm_next;

    logic              tbl_valid_reg [TABLE_ENTRIES];
    logic [QW-1:0]     tbl_from_reg  [TABLE_ENTRIES];
    logic [SW-1:0]     tbl_sym_reg   [TABLE_ENTRIES];
    logic [SW-1:0]     tbl_key_reg   [TABLE_ENTRIES];
    logic [QW-1:0]     tbl_to_reg    [TABLE_ENTRIES];
    pda_pkg::stack_op_t tbl_op_reg   [TABLE_ENTRIES];
    logic [SW-1:0]     tbl_pch_reg   [TABLE_ENTRIES];

    logic [SW-1:0]     stack_mem [STACK_DEPTH];
    logic [SW-1:0]     rdata_reg;

    logic [QW-1:0]     state_reg, state_next;
    logic [SPW-1:0]    sp_reg, sp_next;
    logic [SW-1:0]     top_reg, top_next;
    logic              halted_reg, halted_next;
    pda_pkg::status_t  last_reg, last_next;
    pda_pkg::status_t  res_reg, res_next;
    logic [EW-1:0]     eps_reg, eps_next;
    logic              end_reg, end_next;
    logic              cont_reg, cont_next;
    logic [SW-1:0]     sym_reg, sym_next;
    logic [TABLE_ENTRIES-1:0] mv_sym_reg, mv_sym_next;
    logic [TABLE_ENTRIES-1:0] mv_eps_reg, mv_eps_next;

    logic              out_valid_reg, out_valid_next;
    pda_pkg::status_t  out_status_reg, out_status_next;
    logic [QW-1:0]     out_state_reg, out_state_next;
    logic [pda_pkg::DEPTH_W-1:0] out_depth_reg, out_depth_next;
    logic              out_done_reg, out_done_next;
    logic              out_acc_reg, out_acc_next;

    logic [SW-1:0]     top_eff;
    logic [TW-1:0]     sel_sym, sel_eps, sel;
    logic              any_sym, any_eps;
    logic              do_apply, need_refill, slot_ok, out_free;
    logic [TW-1:0]     wr_slot;
    pda_pkg::status_t  apply_st;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [SW-1:0]     mem_wdata;
    logic [SPW-1:0]    sp_less2;

    assign top_eff  = (sp_reg > SPW'(1)) ? top_reg : bottom_cfg;
    assign any_sym  = |mv_sym_reg;
    assign any_eps  = |mv_eps_reg;
    assign out_free = !out_valid_reg || result_ready;
    assign slot_ok  = (32'(q_data.entry_index) < TABLE_ENTRIES);
    assign wr_slot  = TW'(q_data.entry_index);
    assign sp_less2 = sp_reg - SPW'(2);

    always_comb
    begin
        sel_sym = '0;
        sel_eps = '0;
        for (int e = TABLE_ENTRIES - 1; e >= 0; e--)
        begin
            if (mv_sym_reg[e])
            begin
                sel_sym = TW'(e);
            end
            if (mv_eps_reg[e])
            begin
                sel_eps = TW'(e);
            end
        end
    end

    always_comb
    begin
        for (int e = 0; e < TABLE_ENTRIES; e++)
        begin
            mv_sym_next[e] = tbl_valid_reg[e] && tbl_from_reg[e] == state_reg
                && tbl_sym_reg[e] == sym_reg && tbl_key_reg[e] == top_eff;
            mv_eps_next[e] = tbl_valid_reg[e] && tbl_from_reg[e] == state_reg
                && tbl_sym_reg[e] == pda_pkg::EPSILON_SYM && tbl_key_reg[e] == top_eff;
        end
    end

    // which move the select step takes, if any
    always_comb
    begin
        do_apply = 1'b0;
        sel      = sel_eps;
        if (fsm_reg == pda_pkg::BK_SELECT)
        begin
            if (!end_reg && any_sym)
            begin
                do_apply = 1'b1;
                sel      = sel_sym;
            end
            else if (end_reg)
            begin
                do_apply = any_eps;
            end
            else
            begin
                do_apply = any_eps && (eps_reg < EW'(EPSILON_LIMIT));
            end
        end
    end

    always_comb
    begin
        unique case (fsm_reg)
            pda_pkg::BK_IDLE:
            begin
                fsm_next = pda_pkg::BK_IDLE;
                if (!q_empty)
                begin
                    if ((q_data.action == pda_pkg::ACT_FEED && !halted_reg && q_data.in_alpha)
                        || (q_data.action == pda_pkg::ACT_END && !halted_reg))
                    begin
                        fsm_next = pda_pkg::BK_MATCH;
                    end
                    else
                    begin
                        fsm_next = pda_pkg::BK_RESULT;
                    end
                end
            end
            pda_pkg::BK_MATCH:
            begin
                fsm_next = pda_pkg::BK_SELECT;
            end
            pda_pkg::BK_SELECT:
            begin
                if (!do_apply)
                begin
                    fsm_next = pda_pkg::BK_RESULT;
                end
                else if (need_refill)
                begin
                    fsm_next = pda_pkg::BK_REFILL;
                end
                else if (!end_reg && !any_sym)
                begin
                    fsm_next = pda_pkg::BK_MATCH;
                end
                else
                begin
                    fsm_next = pda_pkg::BK_RESULT;
                end
            end
            pda_pkg::BK_REFILL:
            begin
                fsm_next = cont_reg ? pda_pkg::BK_MATCH : pda_pkg::BK_RESULT;
            end
            pda_pkg::BK_RESULT:
            begin
                fsm_next = out_free ? pda_pkg::BK_IDLE : pda_pkg::BK_RESULT;
            end
            default:
            begin
                fsm_next = pda_pkg::BK_IDLE;
            end
        endcase
    end

    // one move: stack effect and its error code
    always_comb
    begin
        apply_st    = pda_pkg::ST_OK;
        need_refill = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = sp_reg[AW-1:0];
        mem_raddr   = sp_less2[AW-1:0];
        mem_wdata   = tbl_pch_reg[sel];
        if (do_apply)
        begin
            case (tbl_op_reg[sel])
                pda_pkg::SOP_PUSH:
                begin
                    if (sp_reg >= SPW'(STACK_DEPTH))
                    begin
                        apply_st = pda_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                    end
                end
                pda_pkg::SOP_POP:
                begin
                    if (sp_reg <= SPW'(1))
                    begin
                        apply_st = pda_pkg::ST_BOTTOM_POP;
                    end
                    else if (sp_reg > SPW'(2))
                    begin
                        mem_re      = 1'b1;
                        need_refill = 1'b1;
                    end
                end
                pda_pkg::SOP_REPLACE:
                begin
                    if (sp_reg <= SPW'(1))
                    begin
                        if (tbl_pch_reg[sel] != bottom_cfg)
                        begin
                            apply_st = pda_pkg::ST_BOTTOM_POP;
                        end
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = sp_less2[AW-1:0] + AW'(1);
                    end
                end
                default:
                begin
                    apply_st = pda_pkg::ST_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        sp_next         = sp_reg;
        top_next        = top_reg;
        halted_next     = halted_reg;
        last_next       = last_reg;
        res_next        = res_reg;
        eps_next        = eps_reg;
        end_next        = end_reg;
        cont_next       = cont_reg;
        sym_next        = sym_reg;
        q_pop           = 1'b0;
        out_valid_next  = out_valid_reg && !result_ready;
        out_status_next = out_status_reg;
        out_state_next  = out_state_reg;
        out_depth_next  = out_depth_reg;
        out_done_next   = out_done_reg;
        out_acc_next    = out_acc_reg;

        unique case (fsm_reg)
            pda_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    res_next = pda_pkg::ST_OK;
                    eps_next = '0;
                    sym_next = q_data.symbol;
                    end_next = (q_data.action == pda_pkg::ACT_END);
                    if (q_data.action == pda_pkg::ACT_FEED)
                    begin
                        if (halted_reg)
                        begin
                            res_next = last_reg;
                        end
                        else if (!q_data.in_alpha)
                        begin
                            res_next    = pda_pkg::ST_NOT_ALPHA;
                            halted_next = 1'b1;
                            if (last_reg == pda_pkg::ST_OK)
                            begin
                                last_next = pda_pkg::ST_NOT_ALPHA;
                            end
                        end
                    end
                end
            end
            pda_pkg::BK_SELECT:
            begin
                cont_next = !end_reg && !any_sym;
                if (do_apply)
                begin
                    state_next = tbl_to_reg[sel];
                    if (!end_reg && !any_sym)
                    begin
                        eps_next = eps_reg + EW'(1);
                    end
                    if (apply_st != pda_pkg::ST_OK)
                    begin
                        res_next = apply_st;
                        if (last_reg == pda_pkg::ST_OK)
                        begin
                            last_next = apply_st;
                        end
                    end
                    else if (tbl_op_reg[sel] == pda_pkg::SOP_PUSH)
                    begin
                        sp_next  = sp_reg + SPW'(1);
                        top_next = tbl_pch_reg[sel];
                    end
                    else if (tbl_op_reg[sel] == pda_pkg::SOP_POP)
                    begin
                        sp_next = sp_reg - SPW'(1);
                    end
                    else if (tbl_op_reg[sel] == pda_pkg::SOP_REPLACE && sp_reg > SPW'(1))
                    begin
                        top_next = tbl_pch_reg[sel];
                    end
                end
                else if (!end_reg)
                begin
                    res_next    = pda_pkg::ST_NO_MOVE;
                    halted_next = 1'b1;
                    if (last_reg == pda_pkg::ST_OK)
                    begin
                        last_next = pda_pkg::ST_NO_MOVE;
                    end
                end
            end
            pda_pkg::BK_REFILL:
            begin
                top_next = rdata_reg;
            end
            pda_pkg::BK_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_state_next  = state_reg;
                    out_depth_next  = pda_pkg::DEPTH_W'(sp_reg);
                    out_done_next   = end_reg;
                    out_status_next = end_reg ? last_reg : res_reg;
                    out_acc_next    = end_reg && !halted_reg && last_reg == pda_pkg::ST_OK
                        && sp_reg == SPW'(1) && 32'(state_reg) < NUM_STATES
                        && accept_mask_cfg[state_reg];
                    if (end_reg)
                    begin
                        state_next  = initial_state_cfg;
                        sp_next     = SPW'(1);
                        halted_next = 1'b0;
                        last_next   = pda_pkg::ST_OK;
                    end
                end
            end
            default:
            begin
                cont_next = cont_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= pda_pkg::BK_IDLE;
            state_reg     <= '0;
            sp_reg        <= SPW'(1);
            halted_reg    <= 1'b0;
            last_reg      <= pda_pkg::ST_OK;
            out_valid_reg <= 1'b0;
            for (int e = 0; e < TABLE_ENTRIES; e++)
            begin
                tbl_valid_reg[e] <= 1'b0;
            end
        end
        else
        begin
            fsm_reg       <= fsm_next;
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            halted_reg    <= halted_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            if (q_pop && q_data.action == pda_pkg::ACT_LOAD && slot_ok)
            begin
                tbl_valid_reg[wr_slot] <= q_data.entry_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg        <= top_next;
        res_reg        <= res_next;
        eps_reg        <= eps_next;
        end_reg        <= end_next;
        cont_reg       <= cont_next;
        sym_reg        <= sym_next;
        mv_sym_reg     <= mv_sym_next;
        mv_eps_reg     <= mv_eps_next;
        out_status_reg <= out_status_next;
        out_state_reg  <= out_state_next;
        out_depth_reg  <= out_depth_next;
        out_done_reg   <= out_done_next;
        out_acc_reg    <= out_acc_next;
        if (q_pop && q_data.action == pda_pkg::ACT_LOAD && slot_ok)
        begin
            tbl_from_reg[wr_slot] <= q_data.from_state;
            tbl_sym_reg[wr_slot]  <= q_data.symbol;
            tbl_key_reg[wr_slot]  <= q_data.stack_key;
            tbl_to_reg[wr_slot]   <= q_data.to_state;
            tbl_op_reg[wr_slot]   <= q_data.stack_op;
            tbl_pch_reg[wr_slot]  <= q_data.push_char;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= stack_mem[mem_raddr];
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign state_now    = out_state_reg;
    assign depth_now    = out_depth_reg;
    assign word_done    = out_done_reg;
    assign accepted     = out_acc_reg;

endmodule

FILE: hdl/pushdown_automaton_recognizer.sv
// Table-driven pushdown recognizer. Every input beat gives exactly one result beat.
// A beat enters a two-entry queue. The back end goes from idle to its result step
// for loads, ended words that already halted and feeds refused up front; a feed that
// finds its move at once runs match, select and result, with a refill step between
// when a pop exposes a stacked entry, which needs one stack memory read. Each epsilon
// move repeats match and select, up to EPSILON_LIMIT of them; end of word runs match,
// select, refill if needed, and result. All table slots are compared at once into a
// registered match vector, then the lowest matching slot is applied. Configuration
// must be written only while idle (not enforced); no clearing pass is needed.
module pushdown_automaton_recognizer #(
    parameter int NUM_STATES    = pda_pkg::DEF_NUM_STATES,
    parameter int TABLE_ENTRIES = pda_pkg::DEF_TABLE_ENTRIES,
    parameter int STACK_DEPTH   = pda_pkg::DEF_STACK_DEPTH,
    parameter int EPSILON_LIMIT = pda_pkg::DEF_EPSILON_LIMIT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            write_en,
    input  logic [pda_pkg::CFG_IDX_W-1:0]   write_index,
    input  logic [pda_pkg::CFG_W-1:0]       write_data,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic [1:0]                      action,
    input  logic [pda_pkg::SYM_W-1:0]       symbol,
    input  logic                            member,
    input  logic [pda_pkg::SLOT_W-1:0]      entry_index,
    input  logic                            entry_valid,
    input  logic [pda_pkg::STATE_W-1:0]     from_state,
    input  logic [pda_pkg::SYM_W-1:0]       stack_key,
    input  logic [pda_pkg::STATE_W-1:0]     to_state,
    input  logic [1:0]                      stack_op,
    input  logic [pda_pkg::SYM_W-1:0]       push_char,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [pda_pkg::STATUS_W-1:0]    status,
    output logic [pda_pkg::STATE_W-1:0]     state_now,
    output logic [pda_pkg::DEPTH_W-1:0]     depth_now,
    output logic                            word_done,
    output logic                            accepted
);

    logic [pda_pkg::STATE_W-1:0] initial_state_reg;
    logic [pda_pkg::MASK_W-1:0]  accept_mask_reg;
    logic [pda_pkg::SYM_W-1:0]   bottom_reg;

    pda_pkg::cmd_t       front_cmd, back_cmd;
    pda_pkg::queue_ctl_t q_ctl;
    logic                front_push, back_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            initial_state_reg <= '0;
            accept_mask_reg   <= '0;
            bottom_reg        <= pda_pkg::BOTTOM_RESET;
        end
        else if (write_en)
        begin
            unique case (write_index)
                pda_pkg::REG_INITIAL: initial_state_reg <= write_data[pda_pkg::STATE_W-1:0];
                pda_pkg::REG_ACCEPT:  accept_mask_reg   <= write_data[pda_pkg::MASK_W-1:0];
                pda_pkg::REG_BOTTOM:  bottom_reg        <= write_data[pda_pkg::SYM_W-1:0];
                default:              bottom_reg        <= bottom_reg;
            endcase
        end
    end

    pda_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .action      (action),
        .symbol      (symbol),
        .member      (member),
        .entry_index (entry_index),
        .entry_valid (entry_valid),
        .from_state  (from_state),
        .stack_key   (stack_key),
        .to_state    (to_state),
        .stack_op    (stack_op),
        .push_char   (push_char),
        .q_full      (q_ctl.full),
        .q_push      (front_push),
        .q_data      (front_cmd)
    );

    pda_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (front_push),
        .wr_data (front_cmd),
        .pop     (back_pop),
        .rd_data (back_cmd),
        .ctl     (q_ctl)
    );

    pda_back #(
        .NUM_STATES    (NUM_STATES),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .STACK_DEPTH   (STACK_DEPTH),
        .EPSILON_LIMIT (EPSILON_LIMIT)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_empty           (q_ctl.empty),
        .q_pop             (back_pop),
        .q_data            (back_cmd),
        .initial_state_cfg (initial_state_reg),
        .accept_mask_cfg   (accept_mask_reg),
        .bottom_cfg        (bottom_reg),
        .result_valid      (result_valid),
        .result_ready      (result_ready),
        .status            (status),
        .state_now         (state_now),
        .depth_now         (depth_now),
        .word_done         (word_done),
        .accepted          (accepted)
    );

endmodule

FILE: hdl/pda_checker.sv
module pda_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [pda_pkg::STATUS_W-1:0]  status,
    input logic [pda_pkg::DEPTH_W-1:0]   depth_now,
    input logic                          word_done,
    input logic                          accepted
);

    // an accepted word is always an end-of-word beat
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && accepted |-> word_done)
        else $error("accept outside end of word");

    // acceptance needs a clean word with only the bottom left
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && accepted |-> status == pda_pkg::ST_OK && depth_now == 9'd1)
        else $error("accept with error or stack left");

    // bottom marker is never removed
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> depth_now != '0)
        else $error("empty stack reported");

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(status)
        && $stable(depth_now) && $stable(word_done))
        else $error("result beat dropped or changed");

endmodule

bind pushdown_automaton_recognizer pda_checker u_pda_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .depth_now    (depth_now),
    .word_done    (word_done),
    .accepted     (accepted)
);
